FILE: rtl/packed_rgb444_pixel_writer_core_assert.svh
// assertion macros shared by the pixel writer rtl
`ifndef PACKED_RGB444_PIXEL_WRITER_CORE_ASSERT_SVH
`define PACKED_RGB444_PIXEL_WRITER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PRW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pixel writer assertion failed");
// expression must never be true out of reset
`define PRW_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pixel writer forbidden condition seen");
`else
`define PRW_ASSERT(lbl, clk, rst_n, prop)
`define PRW_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: rtl/prw_pkg.sv
// shared types, constants and pixel helpers for the pixel writer
package prw_pkg;

    // default geometry
    localparam int WIDTH_DEF       = 320;
    localparam int HEIGHT_DEF      = 170;
    localparam int STORE_WORDS_DEF = 54400;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_PIXEL_FORMAT = 1'b0;

    // pixel format codes
    localparam logic FMT_DIRECT = 1'b0;
    localparam logic FMT_PACKED = 1'b1;

    // request commands
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // keep masks for the read-modify-write merge
    localparam logic [15:0] KEEP_LOW4   = 16'h000F;
    localparam logic [15:0] KEEP_HIGH12 = 16'hFFF0;
    localparam logic [15:0] KEEP_LOW8   = 16'h00FF;
    localparam logic [15:0] KEEP_HIGH8  = 16'hFF00;
    localparam logic [15:0] KEEP_LOW12  = 16'h0FFF;
    localparam logic [15:0] KEEP_HIGH4  = 16'hF000;

    typedef struct packed {
        logic        cmd;
        logic [8:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [15:0] color565;
        logic [15:0] word_address;
    } pix_req_t;

    typedef struct packed {
        logic [15:0] read_word;
        logic        range_error;
    } pix_rsp_t;

    // operations of the shared address unit
    typedef enum logic [1:0] {
        UOP_LIN  = 2'd0,
        UOP_X12  = 2'd1,
        UOP_LAST = 2'd2
    } unit_op_t;

    typedef struct packed {
        logic     en;
        unit_op_t op;
    } unit_ctl_t;

    typedef struct packed {
        logic we;
        logic re;
    } ram_ctl_t;

    // top four bits of each rgb565 channel
    function automatic logic [11:0] to_rgb444(input logic [15:0] c);
        return {c[15:12], c[10:7], c[4:1]};
    endfunction

    // place the 12-bit color msb-first at nibble offset off of the first
    // or the second touched word
    function automatic logic [15:0] merge_word(input logic [15:0] old,
                                               input logic [11:0] c,
                                               input logic [1:0]  off,
                                               input logic        second);
        logic [15:0] res;
        if (!second) begin
            case (off)
                2'd0:    res = (old & KEEP_LOW4)   | {c, 4'h0};
                2'd1:    res = (old & KEEP_HIGH4)  | {4'h0, c};
                2'd2:    res = (old & KEEP_HIGH8)  | {8'h00, c[11:4]};
                default: res = (old & KEEP_HIGH12) | {12'h000, c[11:8]};
            endcase
        end else if (off == 2'd2) begin
            res = (old & KEEP_LOW12) | {c[3:0], 12'h000};
        end else begin
            res = (old & KEEP_LOW8) | {c[7:0], 8'h00};
        end
        return res;
    endfunction

endpackage

FILE: rtl/prw_frame_ram.sv
// single-port frame store with registered read data
module prw_frame_ram #(
    parameter int DEPTH = prw_pkg::STORE_WORDS_DEF,
    parameter int AW    = 16
) (
    input  logic              aclk,
    input  prw_pkg::ram_ctl_t ctl,
    input  logic [AW-1:0]     addr,
    input  logic [15:0]       wdata,
    output logic [15:0]       rdata
);

    logic [15:0] frame_mem [DEPTH];
    logic [15:0] rdata_reg;

    // one access per cycle, read data held until the next read
    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            frame_mem[addr] <= wdata;
        end
        if (ctl.re) begin
            rdata_reg <= frame_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/prw_shared_unit.sv
// shared address unit: one adder fed by a constant multiply or shifts
module prw_shared_unit #(
    parameter int ACC_W = 20,
    parameter int WIDTH = prw_pkg::WIDTH_DEF
) (
    input  logic               aclk,
    input  prw_pkg::unit_ctl_t ctl,
    input  logic [ACC_W-1:0]   opa,
    input  logic [ACC_W-1:0]   opb,
    output logic [ACC_W-1:0]   res
);

    localparam logic [ACC_W-1:0] WIDTH_C = ACC_W'(WIDTH);

    logic [ACC_W-1:0] addend_a;
    logic [ACC_W-1:0] addend_b;
    logic [ACC_W-1:0] res_reg;
    logic [ACC_W-1:0] res_next;

    // operand selection in front of the single adder
    always_comb begin
        case (ctl.op)
            prw_pkg::UOP_LIN: begin
                addend_a = opa * WIDTH_C;
                addend_b = opb;
            end
            prw_pkg::UOP_X12: begin
                addend_a = opa << 3;
                addend_b = opa << 2;
            end
            prw_pkg::UOP_LAST: begin
                addend_a = opa >> 4;
                addend_b = ACC_W'(opa[3]);
            end
            default: begin
                addend_a = '0;
                addend_b = '0;
            end
        endcase
        res_next = ctl.en ? addend_a + addend_b : res_reg;
    end

    // result held until the next enabled pass
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

FILE: rtl/packed_rgb444_pixel_writer_core.sv
// Pixel writer over a frame store of STORE_WORDS 16-bit words. After reset the store is
// cleared one word per cycle, all STORE_WORDS words (54400 by default), with s_ready low;
// configuration writes are taken meanwhile. Items are handled one at a time: a read
// passes through ST_RD and ST_DONE, a direct RGB565 draw through ST_LIN, ST_POS and
// ST_DONE, a packed RGB444 draw through ST_LIN, ST_POS, ST_CHK, ST_RNG, ST_RD0, ST_WR0
// (ST_RD1, ST_WR1 when it touches two words) and ST_DONE. A draw off the panel or a read
// with an address beyond the store goes straight to ST_DONE; a draw on the panel that runs
// past the store ends after its check (ST_POS direct, ST_RNG packed). A packed draw makes
// three passes through the shared address unit (linear index, bit offset, last word) and
// a read-modify-write of each touched word through the single memory port. A result
// waits in the output register while the next request is accepted; while it waits, the
// next result holds the sequencer and s_ready stays low until m_ready frees the register.
`include "packed_rgb444_pixel_writer_core_assert.svh"

module packed_rgb444_pixel_writer_core #(
    parameter int WIDTH       = prw_pkg::WIDTH_DEF,
    parameter int HEIGHT      = prw_pkg::HEIGHT_DEF,
    parameter int STORE_WORDS = prw_pkg::STORE_WORDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  prw_pkg::pix_req_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output prw_pkg::pix_rsp_t              m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prw_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [prw_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [prw_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int AW    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int ACC_W = $clog2(WIDTH * HEIGHT * 12 + 16);
    localparam int EXT_A = (ACC_W > 16) ? ACC_W : 16;
    localparam int EXT_W = (EXT_A > AW) ? EXT_A : AW;
    localparam int CMP_W = EXT_W + 1;

    localparam logic [CMP_W-1:0] STORE_LIM  = CMP_W'(STORE_WORDS);
    localparam logic [AW-1:0]    CLR_LAST   = AW'(STORE_WORDS - 1);
    localparam logic [10:0]      WIDTH_LIM  = 11'(WIDTH);
    localparam logic [10:0]      HEIGHT_LIM = 11'(HEIGHT);

    typedef enum logic [11:0] {
        ST_CLEAR = 12'b0000_0000_0001,
        ST_IDLE  = 12'b0000_0000_0010,
        ST_LIN   = 12'b0000_0000_0100,
        ST_POS   = 12'b0000_0000_1000,
        ST_CHK   = 12'b0000_0001_0000,
        ST_RNG   = 12'b0000_0010_0000,
        ST_RD0   = 12'b0000_0100_0000,
        ST_WR0   = 12'b0000_1000_0000,
        ST_RD1   = 12'b0001_0000_0000,
        ST_WR1   = 12'b0010_0000_0000,
        ST_RD    = 12'b0100_0000_0000,
        ST_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              fmt_reg, fmt_next;
    logic              m_valid_reg, m_valid_next;
    prw_pkg::pix_rsp_t m_data_reg, m_data_next;
    prw_pkg::pix_req_t req_reg, req_next;
    logic [AW-1:0]     w_reg, w_next;
    logic [1:0]        off_reg, off_next;
    logic              err_reg, err_next;

    prw_pkg::unit_ctl_t unit_ctl;
    logic [ACC_W-1:0]   unit_a;
    logic [ACC_W-1:0]   unit_b;
    logic [ACC_W-1:0]   unit_res;

    prw_pkg::ram_ctl_t ram_ctl;
    logic [AW-1:0]     ram_addr;
    logic [15:0]       ram_wdata;
    logic [15:0]       ram_rdata;

    logic              cfg_write;
    logic              xy_ok;
    logic              addr_ok;
    logic              res_ok;
    logic [EXT_W-1:0]  res_ext;
    logic [EXT_W-1:0]  word_ext;
    logic [EXT_W-1:0]  raddr_ext;
    logic [11:0]       color444;

    // shared address unit
    prw_shared_unit #(
        .ACC_W (ACC_W),
        .WIDTH (WIDTH)
    ) u_unit (
        .aclk (aclk),
        .ctl  (unit_ctl),
        .opa  (unit_a),
        .opb  (unit_b),
        .res  (unit_res)
    );

    // frame store
    prw_frame_ram #(
        .DEPTH (STORE_WORDS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // configuration register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == prw_pkg::REG_PIXEL_FORMAT) ?
                       prw_pkg::CFG_DATA_W'(fmt_reg) : '0;
    assign fmt_next  = (cfg_write && paddr[2] == prw_pkg::REG_PIXEL_FORMAT) ?
                       pwdata[0] : fmt_reg;

    // range checks and address views
    assign xy_ok     = (11'(s_data.pixel_x) < WIDTH_LIM) && (11'(s_data.pixel_y) < HEIGHT_LIM);
    assign addr_ok   = CMP_W'(s_data.word_address) < STORE_LIM;
    assign res_ok    = CMP_W'(unit_res) < STORE_LIM;
    assign res_ext   = EXT_W'(unit_res);
    assign word_ext  = EXT_W'(unit_res >> 4);
    assign raddr_ext = EXT_W'(req_reg.word_address);
    assign color444  = prw_pkg::to_rgb444(req_reg.color565);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        req_next     = req_reg;
        w_next       = w_reg;
        off_next     = off_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        unit_ctl     = '{en: 1'b0, op: prw_pkg::UOP_LIN};
        unit_a       = '0;
        unit_b       = '0;
        ram_ctl      = '0;
        ram_addr     = '0;
        ram_wdata    = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_ctl.we = 1'b1;
                ram_addr   = clr_cnt_reg;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    err_next = 1'b0;
                    if (s_data.cmd == prw_pkg::CMD_READ) begin
                        if (addr_ok) begin
                            state_next = ST_RD;
                        end else begin
                            err_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                    end else if (xy_ok) begin
                        state_next = ST_LIN;
                    end else begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            // linear pixel index y*WIDTH + x
            ST_LIN: begin
                unit_ctl   = '{en: 1'b1, op: prw_pkg::UOP_LIN};
                unit_a     = ACC_W'(req_reg.pixel_y);
                unit_b     = ACC_W'(req_reg.pixel_x);
                state_next = ST_POS;
            end
            // direct store, or bit offset of the packed pixel
            ST_POS: begin
                if (fmt_reg == prw_pkg::FMT_DIRECT) begin
                    if (res_ok) begin
                        ram_ctl.we = 1'b1;
                        ram_addr   = res_ext[AW-1:0];
                        ram_wdata  = req_reg.color565;
                    end else begin
                        err_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end else begin
                    unit_ctl   = '{en: 1'b1, op: prw_pkg::UOP_X12};
                    unit_a     = unit_res;
                    state_next = ST_CHK;
                end
            end
            // split bit offset, work out the last touched word
            ST_CHK: begin
                unit_ctl   = '{en: 1'b1, op: prw_pkg::UOP_LAST};
                unit_a     = unit_res;
                w_next     = word_ext[AW-1:0];
                off_next   = unit_res[3:2];
                state_next = ST_RNG;
            end
            ST_RNG: begin
                if (res_ok) begin
                    state_next = ST_RD0;
                end else begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_RD0: begin
                ram_ctl.re = 1'b1;
                ram_addr   = w_reg;
                state_next = ST_WR0;
            end
            ST_WR0: begin
                ram_ctl.we = 1'b1;
                ram_addr   = w_reg;
                ram_wdata  = prw_pkg::merge_word(ram_rdata, color444, off_reg, 1'b0);
                state_next = off_reg[1] ? ST_RD1 : ST_DONE;
            end
            // second word sits at the last-word address left in the unit
            ST_RD1: begin
                ram_ctl.re = 1'b1;
                ram_addr   = res_ext[AW-1:0];
                state_next = ST_WR1;
            end
            ST_WR1: begin
                ram_ctl.we = 1'b1;
                ram_addr   = res_ext[AW-1:0];
                ram_wdata  = prw_pkg::merge_word(ram_rdata, color444, off_reg, 1'b1);
                state_next = ST_DONE;
            end
            ST_RD: begin
                ram_ctl.re = 1'b1;
                ram_addr   = raddr_ext[AW-1:0];
                state_next = ST_DONE;
            end
            // hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.range_error = err_reg;
                    m_data_next.read_word   =
                        (req_reg.cmd == prw_pkg::CMD_READ && !err_reg) ? ram_rdata : 16'h0000;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            fmt_reg     <= prw_pkg::FMT_PACKED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            fmt_reg     <= fmt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        w_reg      <= w_next;
        off_reg    <= off_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
    end

    // checks
    `PRW_ASSERT(a_we_states, aclk, aresetn,
        ram_ctl.we |-> (state_reg == ST_CLEAR || state_reg == ST_POS ||
                        state_reg == ST_WR0 || state_reg == ST_WR1))
    `PRW_ASSERT(a_second_word, aclk, aresetn, (state_reg == ST_RD1) |-> off_reg[1])
    `PRW_ASSERT(a_done_loads, aclk, aresetn,
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=>
        (m_valid_reg && state_reg == ST_IDLE))
    `PRW_ASSERT(a_err_zero, aclk, aresetn,
        (m_valid && m_data.range_error) |-> (m_data.read_word == 16'h0000))
    `PRW_ASSERT_NEVER(a_one_access, aclk, aresetn, ram_ctl.we && ram_ctl.re)

endmodule

FILE: verif/tb.sv
// testbench for the packed rgb444 pixel writer: random draws and reads against a frame model
`timescale 1ns / 1ps

module tb;

    localparam int PANEL_W        = prw_pkg::WIDTH_DEF;
    localparam int PANEL_H        = prw_pkg::HEIGHT_DEF;
    localparam int FRAME_WORDS    = prw_pkg::STORE_WORDS_DEF;
    localparam int REG_UNMAPPED   = 1;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 250000;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 235;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    prw_pkg::pix_req_t s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    prw_pkg::pix_rsp_t m_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [prw_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [prw_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [prw_pkg::CFG_DATA_W-1:0] prdata;
    logic              pready;

    // frame model and format register copy
    bit [15:0]   frame_mem [0:FRAME_WORDS-1];
    logic        fmt_copy = prw_pkg::FMT_PACKED;

    prw_pkg::pix_req_t pending_reqs [$];
    prw_pkg::pix_rsp_t expected_rsps [$];

    logic        req_taken = 1'b0;
    logic        rsp_taken = 1'b0;
    int          send_gap = 0;
    int          recv_stall = 0;
    int          hold_left = 0;
    int          rsp_count = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          quiet = 1'b0;
    int          hot_x = 0;
    int          hot_y = 0;
    int          last_word = 0;

    packed_rgb444_pixel_writer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // idle length for one request or result
    function automatic int pick_wait();
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // apply one request to the frame model and return the result it gives
    function automatic prw_pkg::pix_rsp_t predict_pixel_rsp(input prw_pkg::pix_req_t req);
        prw_pkg::pix_rsp_t rsp;
        int          lin;
        int          bitpos;
        int          pos;
        int          wi;
        int          sh;
        logic [11:0] c12;
        logic [3:0]  nib;
        rsp = '0;
        if (req.cmd == prw_pkg::CMD_READ) begin
            if (int'(req.word_address) < FRAME_WORDS)
                rsp.read_word = frame_mem[req.word_address];
            else
                rsp.range_error = 1'b1;
        end else if (int'(req.pixel_x) >= PANEL_W || int'(req.pixel_y) >= PANEL_H) begin
            rsp.range_error = 1'b1;
        end else begin
            lin = int'(req.pixel_x) + int'(req.pixel_y) * PANEL_W;
            if (fmt_copy == prw_pkg::FMT_DIRECT) begin
                if (lin >= FRAME_WORDS)
                    rsp.range_error = 1'b1;
                else
                    frame_mem[lin] = req.color565;
            end else begin
                bitpos = lin * 12;
                if (((bitpos + 8) >> 4) >= FRAME_WORDS) begin
                    rsp.range_error = 1'b1;
                end else begin
                    // keep the upper four bits of red, green and blue
                    c12 = {req.color565[15:12], req.color565[10:7], req.color565[4:1]};
                    for (int k = 0; k < 3; k++) begin
                        pos = bitpos + 4 * k;
                        wi = pos >> 4;
                        sh = 12 - (pos % 16);
                        nib = 4'(c12 >> (8 - 4 * k));
                        frame_mem[wi] = (frame_mem[wi] & ~(16'h000F << sh))
                                        | ({12'h000, nib} << sh);
                    end
                end
            end
        end
        return rsp;
    endfunction

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (s_valid && !req_taken) begin
            // hold the request until it is taken
        end else if (send_gap != 0) begin
            s_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_reqs.size() != 0) begin
            s_data <= pending_reqs.pop_front();
            s_valid <= 1'b1;
            send_gap <= pick_wait();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result receiver with random stalls and occasional long hold-offs
    always @(negedge aclk) begin : rsp_drive
        int n;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall <= 0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rsp_taken && (rsp_count == 400 || rsp_count == 1300)) begin
            m_ready <= 1'b0;
            hold_left <= LONG_HOLD;
        end else if (rsp_taken) begin
            n = pick_wait();
            m_ready <= (n == 0);
            recv_stall <= n;
        end else if (recv_stall != 0) begin
            m_ready <= (recv_stall == 1);
            recv_stall <= recv_stall - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: check results first, then record the prediction for a new request
    always @(posedge aclk) begin : rsp_check
        prw_pkg::pix_rsp_t want;
        if (!aresetn) begin
            req_taken <= 1'b0;
            rsp_taken <= 1'b0;
        end else begin
            req_taken <= s_valid && s_ready;
            rsp_taken <= m_valid && m_ready;
            if (m_valid && m_ready) begin
                rsp_count++;
                if (expected_rsps.size() == 0) begin
                    $display("%0t unexpected result: expected none got %h/%b", $time,
                             m_data.read_word, m_data.range_error);
                    error_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (m_data.read_word !== want.read_word) begin
                        $display("%0t read_word mismatch: expected %h got %h", $time,
                                 want.read_word, m_data.read_word);
                        error_count++;
                    end
                    if (m_data.range_error !== want.range_error) begin
                        $display("%0t range_error mismatch: expected %b got %b", $time,
                                 want.range_error, m_data.range_error);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_rsps.push_back(predict_pixel_rsp(s_data));
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[packed_rgb444_pixel_writer_core] ERROR");
            $finish;
        end
    end

    // apb register write
    task automatic cfg_write(input int index, input logic [prw_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= prw_pkg::CFG_ADDR_W'(index * 4);
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (index == int'(prw_pkg::REG_PIXEL_FORMAT))
            fmt_copy = value[0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // apb readback of the format register
    task automatic cfg_check();
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= prw_pkg::CFG_ADDR_W'(int'(prw_pkg::REG_PIXEL_FORMAT) * 4);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {{(prw_pkg::CFG_DATA_W-1){1'b0}}, fmt_copy}) begin
            $display("%0t pixel_format readback: expected %h got %h", $time,
                     {{(prw_pkg::CFG_DATA_W-1){1'b0}}, fmt_copy}, prdata);
            error_count++;
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_draw(input int x, input int y, input logic [15:0] color);
        prw_pkg::pix_req_t req;
        req.cmd = prw_pkg::CMD_DRAW;
        req.pixel_x = 9'(x);
        req.pixel_y = 8'(y);
        req.color565 = color;
        req.word_address = 16'($urandom_range(0, 65535));
        pending_reqs.push_back(req);
    endtask

    task automatic push_read(input int addr);
        prw_pkg::pix_req_t req;
        req.cmd = prw_pkg::CMD_READ;
        req.pixel_x = 9'($urandom_range(0, 511));
        req.pixel_y = 8'($urandom_range(0, 255));
        req.color565 = 16'($urandom_range(0, 65535));
        req.word_address = 16'(addr);
        pending_reqs.push_back(req);
    endtask

    // random phase: mostly overlapping draws in a small window and reads of touched words
    task automatic queue_random_phase(input int count);
        prw_pkg::pix_req_t req;
        int pick;
        int lin;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            req.cmd = prw_pkg::CMD_DRAW;
            req.pixel_x = 9'($urandom_range(0, 511));
            req.pixel_y = 8'($urandom_range(0, 255));
            req.color565 = 16'($urandom_range(0, 65535));
            req.word_address = 16'($urandom_range(0, 65535));
            if (pick < 45) begin
                req.pixel_x = 9'(hot_x + $urandom_range(0, 7));
                req.pixel_y = 8'(hot_y + $urandom_range(0, 2));
            end else if (pick < 60) begin
                req.pixel_x = 9'($urandom_range(0, PANEL_W - 1));
                req.pixel_y = 8'($urandom_range(0, PANEL_H - 1));
            end else if (pick < 66) begin
                if ($urandom_range(0, 1))
                    req.pixel_x = 9'($urandom_range(PANEL_W, 511));
                else
                    req.pixel_y = 8'($urandom_range(PANEL_H, 255));
            end else begin
                req.cmd = prw_pkg::CMD_READ;
                if (pick < 90)
                    req.word_address = 16'(last_word + $urandom_range(0, 2));
                else if (pick < 97)
                    req.word_address = 16'($urandom_range(0, FRAME_WORDS - 1));
                else
                    req.word_address = 16'($urandom_range(FRAME_WORDS, 65535));
            end
            if (req.cmd == prw_pkg::CMD_DRAW && int'(req.pixel_x) < PANEL_W
                    && int'(req.pixel_y) < PANEL_H) begin
                lin = int'(req.pixel_x) + int'(req.pixel_y) * PANEL_W;
                last_word = (fmt_copy == prw_pkg::FMT_PACKED) ? (lin * 12) >> 4 : lin;
            end
            pending_reqs.push_back(req);
        end
    endtask

    // wait for every request to be sent and every result to arrive
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // stimulus sequence
    initial begin
        logic fmt_plan [RAND_PHASES];
        logic [prw_pkg::CFG_DATA_W-1:0] value;
        fmt_plan = '{prw_pkg::FMT_PACKED, prw_pkg::FMT_DIRECT,
                     prw_pkg::FMT_PACKED, prw_pkg::FMT_PACKED,
                     prw_pkg::FMT_DIRECT, prw_pkg::FMT_PACKED,
                     prw_pkg::FMT_DIRECT, prw_pkg::FMT_PACKED};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // packed format: every nibble offset, panel corners, out-of-range items
        cfg_write(int'(prw_pkg::REG_PIXEL_FORMAT),
                  prw_pkg::CFG_DATA_W'(prw_pkg::FMT_PACKED));
        cfg_check();
        @(posedge aclk);
        push_read(0);
        push_draw(0, 0, 16'hFFFF);
        push_draw(1, 0, 16'h1234);
        push_draw(2, 0, 16'hABCD);
        push_draw(3, 0, 16'h5A5A);
        push_draw(319, 169, 16'hFFFF);
        push_draw(318, 169, 16'h0000);
        push_draw(320, 0, 16'hFFFF);
        push_draw(0, 170, 16'hFFFF);
        push_draw(511, 255, 16'hFFFF);
        for (int a = 0; a < 5; a++)
            push_read(a);
        push_read(40798);
        push_read(40799);
        push_read(FRAME_WORDS - 1);
        push_read(FRAME_WORDS);
        push_read(65535);
        wait_idle();

        // direct format corners
        cfg_write(int'(prw_pkg::REG_PIXEL_FORMAT),
                  prw_pkg::CFG_DATA_W'(prw_pkg::FMT_DIRECT));
        cfg_check();
        @(posedge aclk);
        push_draw(0, 0, 16'hFFFF);
        push_draw(319, 169, 16'hA5A5);
        push_read(0);
        push_read(1);
        push_read(FRAME_WORDS - 1);
        wait_idle();

        // random phases, both formats, some with no idling at all
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0)
                value = '1;
            else if (p == 1)
                value = {{(prw_pkg::CFG_DATA_W-1){1'b1}}, 1'b0};
            else
                value = prw_pkg::CFG_DATA_W'($urandom);
            value[0] = fmt_plan[p];
            cfg_write(int'(prw_pkg::REG_PIXEL_FORMAT), value);
            if (p == 3)
                cfg_write(REG_UNMAPPED, '0);
            cfg_check();
            quiet = (p == 2 || p == 5);
            hot_x = $urandom_range(0, PANEL_W - 8);
            hot_y = $urandom_range(0, PANEL_H - 3);
            @(posedge aclk);
            queue_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        if (error_count == 0)
            $display("[packed_rgb444_pixel_writer_core] OK");
        else
            $display("[packed_rgb444_pixel_writer_core] ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/prw_pkg.sv
rtl/prw_frame_ram.sv
rtl/prw_shared_unit.sv
rtl/packed_rgb444_pixel_writer_core.sv
verif/tb.sv
